>>> rtl/core/bmp565_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp565_pkg: shared types and constants of the BMP to RGB565 stream decoder
// Header byte positions, parser phase codes, result and reject codes, and the
// result record carried from the parser to the output stage.
// ----------------------------------------------------------------------------
package bmp565_pkg;

    // dimension limits (defaults of the top-level parameters)
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // pixel coordinate width and a counter width that also holds the count itself
    localparam int PIX_W = 10;
    localparam int CNT_W = PIX_W + 1;

    // header layout (little-endian fields, position of the last byte of each)
    localparam logic [15:0] BMP_MAGIC  = 16'h4D42;
    localparam logic [31:0] POS_MAGIC  = 32'd1;
    localparam logic [31:0] POS_OFFSET = 32'd13;
    localparam logic [31:0] POS_WIDTH  = 32'd21;
    localparam logic [31:0] POS_HEIGHT = 32'd25;
    localparam logic [31:0] POS_PLANES = 32'd27;
    localparam logic [31:0] HEADER_LEN = 32'd34;
    localparam logic [31:0] POS_LAST   = HEADER_LEN - 32'd1;

    // parser phases
    localparam logic [2:0] PH_HEADER   = 3'd0;
    localparam logic [2:0] PH_SKIP     = 3'd1;
    localparam logic [2:0] PH_PIXELS   = 3'd2;
    localparam logic [2:0] PH_DONE     = 3'd3;
    localparam logic [2:0] PH_REJECTED = 3'd4;

    // byte slot within a pixel triple
    localparam logic [1:0] SLOT_FIRST  = 2'd0;
    localparam logic [1:0] SLOT_SECOND = 2'd1;
    localparam logic [1:0] SLOT_THIRD  = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_PIXEL  = 2'd0;
    localparam logic [1:0] KIND_ACCEPT = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    // reject reasons
    localparam logic [1:0] ERR_MAGIC    = 2'd0;
    localparam logic [1:0] ERR_PLANES   = 2'd1;
    localparam logic [1:0] ERR_COMPRESS = 2'd2;
    localparam logic [1:0] ERR_SIZE     = 2'd3;

    // output tdata: error_code, pixel_x, pixel_y, pixel_color, padded to bytes
    localparam int TDATA_W = 40;

    typedef struct packed {
        logic [1:0]       kind;
        logic [1:0]       err;
        logic [PIX_W-1:0] x;
        logic [PIX_W-1:0] y;
        logic [15:0]      color;
        logic             last;
    } t_result;

endpackage

>>> rtl/core/bmp24_stream_to_rgb565.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp24_stream_to_rgb565: 24-bit BMP byte stream to RGB565 pixel stream
// Parses and checks the BMP header, skips to the pixel data and turns each
// byte triple into one 5-6-5 color tagged with its column and display row.
// ----------------------------------------------------------------------------
// Channel | Dir | tdata bits (low first)                    | tuser       | tlast
// s       | in  | [7:0] data_byte                           | file_start  | -
// m       | out | [1:0] error_code, [11:2] pixel_x,         | result_kind | last_pixel
//         |     | [21:12] pixel_y, [37:22] pixel_color,     |             |
//         |     | [39:38] zero                              |             |
//
// One byte per clock while o_s_tready is high: the parser state updates in the
// cycle the byte is accepted, and its result is registered in the result
// register, or in the skid register while the m side stalls. A byte yields at
// most one result (header verdict or a pixel on every third pixel byte). The
// two-entry output stage absorbs an m-side stall; o_s_tready drops while the
// skid is full and rises again once it drains. Synchronous active-low reset
// clears the parser to wait for a header; no clearing pass is needed.
// ----------------------------------------------------------------------------
module bmp24_stream_to_rgb565
    import bmp565_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // byte stream
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [7:0]         i_s_tdata,   // [7:0] data_byte
    input  logic               i_s_tuser,   // [0] file_start
    // result stream
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [TDATA_W-1:0] o_m_tdata,   // error_code, pixel_x, pixel_y, pixel_color
    output logic [1:0]         o_m_tuser,   // result_kind
    output logic               o_m_tlast    // last_pixel
);

    // stored dimensions hold up to max+1, which marks an oversize header value
    localparam int W_DIM_X = $clog2(MAX_WIDTH + 2);
    localparam int W_DIM_Y = $clog2(MAX_HEIGHT + 2);

    // parser state
    logic [2:0]         r_phase,  n_phase;
    logic [31:0]        r_pos,    n_pos;
    logic [23:0]        r_acc,    n_acc;     // last three header bytes
    logic [31:0]        r_offset, n_offset;
    logic [W_DIM_X-1:0] r_width,  n_width;
    logic [W_DIM_Y-1:0] r_height, n_height;
    logic [PIX_W-1:0]   r_col,    n_col;
    logic [PIX_W-1:0]   r_row,    n_row;
    logic [1:0]         r_slot,   n_slot;
    logic [7:0]         r_b0,     n_b0;
    logic [7:0]         r_b1,     n_b1;

    // output stage
    logic               r_out_valid;
    t_result            r_out;
    logic               r_skd_valid;
    t_result            r_skd;

    logic               w_accept;
    logic               w_take;
    logic [2:0]         w_phase;
    logic [31:0]        w_pos;
    logic [1:0]         w_slot;
    logic [31:0]        w_word;
    logic               w_pixel_byte;
    logic [CNT_W-1:0]   w_col1;
    logic [CNT_W-1:0]   w_row1;
    logic [CNT_W-1:0]   w_wext;
    logic [CNT_W-1:0]   w_hext;
    logic [CNT_W-1:0]   w_ydisp;
    logic               w_last;
    logic               w_size_bad;
    logic               n_res_valid;
    t_result            n_res;

    assign w_accept = i_s_tvalid && o_s_tready;
    assign w_take   = r_out_valid && i_m_tready;

    // a file start restarts the parser on this very byte
    assign w_phase = i_s_tuser ? PH_HEADER  : r_phase;
    assign w_pos   = i_s_tuser ? 32'd0      : r_pos;
    assign w_slot  = i_s_tuser ? SLOT_FIRST : r_slot;

    assign w_word  = {i_s_tdata, r_acc};

    // pixel geometry
    assign w_col1  = {1'b0, r_col} + CNT_W'(1);
    assign w_row1  = {1'b0, r_row} + CNT_W'(1);
    assign w_wext  = CNT_W'(r_width);
    assign w_hext  = CNT_W'(r_height);
    assign w_ydisp = w_hext - CNT_W'(1) - {1'b0, r_row};
    assign w_last  = (w_col1 == w_wext) && (w_row1 == w_hext);

    assign w_size_bad = (r_width == '0)  || (r_width > W_DIM_X'(MAX_WIDTH))
                     || (r_height == '0) || (r_height > W_DIM_Y'(MAX_HEIGHT))
                     || (r_offset < HEADER_LEN);

    always_comb begin
        n_phase      = r_phase;
        n_pos        = r_pos;
        n_acc        = r_acc;
        n_offset     = r_offset;
        n_width      = r_width;
        n_height     = r_height;
        n_col        = r_col;
        n_row        = r_row;
        n_slot       = r_slot;
        n_b0         = r_b0;
        n_b1         = r_b1;
        n_res_valid  = 1'b0;
        n_res        = '0;
        w_pixel_byte = 1'b0;

        if (w_accept) begin
            n_phase = w_phase;
            n_pos   = w_pos;
            n_slot  = w_slot;
            unique case (w_phase)
                PH_HEADER: begin
                    n_acc = w_word[31:8];
                    n_pos = w_pos + 32'd1;
                    case (w_pos)
                        POS_MAGIC: begin
                            if (w_word[31:16] != BMP_MAGIC) begin
                                n_phase     = PH_REJECTED;
                                n_res_valid = 1'b1;
                                n_res.kind  = KIND_REJECT;
                                n_res.err   = ERR_MAGIC;
                            end
                        end
                        POS_OFFSET: n_offset = w_word;
                        POS_WIDTH: begin
                            n_width = (w_word > 32'(MAX_WIDTH)) ?
                                      W_DIM_X'(MAX_WIDTH + 1) : W_DIM_X'(w_word);
                        end
                        POS_HEIGHT: begin
                            n_height = (w_word > 32'(MAX_HEIGHT)) ?
                                       W_DIM_Y'(MAX_HEIGHT + 1) : W_DIM_Y'(w_word);
                        end
                        POS_PLANES: begin
                            if (w_word[31:16] != 16'd1) begin
                                n_phase     = PH_REJECTED;
                                n_res_valid = 1'b1;
                                n_res.kind  = KIND_REJECT;
                                n_res.err   = ERR_PLANES;
                            end
                        end
                        POS_LAST: begin
                            n_res_valid = 1'b1;
                            if (w_word != 32'd0) begin
                                n_phase    = PH_REJECTED;
                                n_res.kind = KIND_REJECT;
                                n_res.err  = ERR_COMPRESS;
                            end else if (w_size_bad) begin
                                n_phase    = PH_REJECTED;
                                n_res.kind = KIND_REJECT;
                                n_res.err  = ERR_SIZE;
                            end else begin
                                // header good: start the pixel grid
                                n_phase    = PH_SKIP;
                                n_col      = '0;
                                n_row      = '0;
                                n_slot     = SLOT_FIRST;
                                n_res.kind = KIND_ACCEPT;
                            end
                        end
                        default: ;
                    endcase
                end
                PH_SKIP: begin
                    if (r_pos < r_offset) begin
                        n_pos = r_pos + 32'd1;
                    end else begin
                        n_phase      = PH_PIXELS;
                        w_pixel_byte = 1'b1;
                    end
                end
                PH_PIXELS: w_pixel_byte = 1'b1;
                default: ;  // done or rejected: drop bytes until the next file start
            endcase

            if (w_pixel_byte) begin
                case (r_slot)
                    SLOT_FIRST: begin
                        n_b0   = i_s_tdata;
                        n_slot = SLOT_SECOND;
                    end
                    SLOT_SECOND: begin
                        n_b1   = i_s_tdata;
                        n_slot = SLOT_THIRD;
                    end
                    default: begin
                        n_slot      = SLOT_FIRST;
                        n_res_valid = 1'b1;
                        n_res.kind  = KIND_PIXEL;
                        n_res.x     = r_col;
                        n_res.y     = w_ydisp[PIX_W-1:0];
                        n_res.color = {r_b0[7:3], r_b1[7:2], i_s_tdata[7:3]};
                        n_res.last  = w_last;
                        // advance across the row, wrap to the next file row
                        if (w_col1 >= w_wext) begin
                            n_col = '0;
                            n_row = w_row1[PIX_W-1:0];
                        end else begin
                            n_col = w_col1[PIX_W-1:0];
                        end
                        if (w_last) begin
                            n_phase = PH_DONE;
                        end
                    end
                endcase
            end
        end
    end

    // parser control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_pos    <= '0;
            r_offset <= 32'd54;
            r_width  <= W_DIM_X'(128);
            r_height <= W_DIM_Y'(160);
            r_col    <= '0;
            r_row    <= '0;
            r_slot   <= SLOT_FIRST;
        end else begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_offset <= n_offset;
            r_width  <= n_width;
            r_height <= n_height;
            r_col    <= n_col;
            r_row    <= n_row;
            r_slot   <= n_slot;
        end
    end

    // header bytes and held pixel bytes
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_b0  <= n_b0;
        r_b1  <= n_b1;
    end

    // output register with skid: a stalled result parks in the skid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (!r_out_valid || w_take) begin
            if (r_skd_valid) begin
                r_out_valid <= 1'b1;
                r_skd_valid <= 1'b0;
            end else begin
                r_out_valid <= n_res_valid;
            end
        end else if (n_res_valid) begin
            r_skd_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_take) begin
            r_out <= r_skd_valid ? r_skd : n_res;
        end else if (n_res_valid) begin
            r_skd <= n_res;
        end
    end

    assign o_s_tready = !r_skd_valid;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tlast  = r_out.last;
    assign o_m_tdata  = {2'b00, r_out.color, r_out.y, r_out.x, r_out.err};

    // the skid register only fills behind a held result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_valid |-> r_out_valid)
        else $error("skid register valid while output register empty");

    // the final pixel closes the image
    a_last_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_res_valid && n_res.kind == KIND_PIXEL && n_res.last) |=> r_phase == PH_DONE)
        else $error("last pixel did not close the image");

    // an accepted header starts a clean pixel grid
    a_accept_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_res_valid && n_res.kind == KIND_ACCEPT)
        |=> (r_phase == PH_SKIP && r_col == '0 && r_row == '0 && r_slot == SLOT_FIRST))
        else $error("header accept without grid restart");

    // pixels only come from the third byte of a triple
    a_pixel_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_res_valid && n_res.kind == KIND_PIXEL) |-> r_slot == SLOT_THIRD)
        else $error("pixel emitted outside the third byte");

    // the triple slot never reaches the unused code
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot != 2'd3)
        else $error("pixel byte slot out of range");

endmodule

>>> test/bmp24_stream_to_rgb565_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp24_stream_to_rgb565_tb: self-checking bench for the BMP to RGB565 decoder
// Streams whole and broken BMP files into the byte port, decodes every
// accepted byte in a local copy of the parser and compares each result on the
// pixel port field by field. Both ports idle and stall at random, and one long
// hold-off on the result side backs the decoder up into its input.
// ----------------------------------------------------------------------------
module bmp24_stream_to_rgb565_tb;
    import bmp565_pkg::*;

    localparam int MAX_W        = MAX_WIDTH_DEF;
    localparam int MAX_H        = MAX_HEIGHT_DEF;
    localparam int GAP_MAX      = 13;
    localparam int RANDOM_ITEMS = 800;
    localparam int HOLD_CYCLES  = 250;
    localparam int DRAIN_CYCLES = 20;

    logic               i_clk;
    logic               i_rst_n    = 1'b0;
    logic               i_s_tvalid = 1'b0;
    logic               o_s_tready;
    logic [7:0]         i_s_tdata  = 8'd0;
    logic               i_s_tuser  = 1'b0;
    logic               o_m_tvalid;
    logic               i_m_tready = 1'b0;
    logic [TDATA_W-1:0] o_m_tdata;   // error_code, pixel_x, pixel_y, pixel_color, pad
    logic [1:0]         o_m_tuser;   // result_kind
    logic               o_m_tlast;   // last_pixel

    // idling switches for the byte source and the result sink
    bit tx_idle  = 1'b1;
    bit rx_idle  = 1'b1;
    int hold_req = 0;

    int n_errors = 0;
    int n_parsed = 0;

    // results the decoder owes us, oldest first
    t_result due_results[$];

    // local copy of the parser state
    logic [2:0]       dec_phase  = PH_HEADER;
    logic [31:0]      dec_pos    = 32'd0;
    logic [31:0]      dec_shift  = 32'd0;
    logic [31:0]      dec_offset = 32'd54;
    logic [10:0]      dec_width  = 11'd128;
    logic [10:0]      dec_height = 11'd160;
    logic [PIX_W-1:0] dec_col    = '0;
    logic [PIX_W-1:0] dec_row    = '0;
    logic [1:0]       dec_slot   = SLOT_FIRST;
    logic [7:0]       dec_b0     = 8'd0;
    logic [7:0]       dec_b1     = 8'd0;

    bmp24_stream_to_rgb565 uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // hold a too-large dimension as max+1, just enough to fail the size check
    function automatic logic [10:0] clamp_dim(input logic [31:0] v, input int lim);
        return (v > 32'(lim)) ? 11'(lim + 1) : v[10:0];
    endfunction

    // Decode one accepted byte and queue the result it causes, if any.
    task automatic decode_byte(input logic [7:0] b, input logic start);
        t_result     r;
        logic        got;
        logic        fin;
        logic [31:0] at;
        logic [10:0] y_full;
        r   = '0;
        got = 1'b0;
        // restart the parser on the first byte of a new file
        if (start) begin
            dec_phase = PH_HEADER;
            dec_pos   = 32'd0;
            dec_shift = 32'd0;
            dec_slot  = SLOT_FIRST;
        end
        // drop everything after a verdict or the last pixel
        if (dec_phase != PH_HEADER && dec_phase != PH_SKIP && dec_phase != PH_PIXELS)
            return;
        n_parsed++;
        if (dec_phase == PH_HEADER) begin
            at        = dec_pos;
            dec_shift = {b, dec_shift[31:8]};
            dec_pos   = dec_pos + 32'd1;
            case (at)
                POS_MAGIC: begin
                    if (dec_shift[31:16] != BMP_MAGIC) begin
                        dec_phase = PH_REJECTED;
                        r.kind    = KIND_REJECT;
                        r.err     = ERR_MAGIC;
                        got       = 1'b1;
                    end
                end
                POS_OFFSET: dec_offset = dec_shift;
                POS_WIDTH:  dec_width  = clamp_dim(dec_shift, MAX_W);
                POS_HEIGHT: dec_height = clamp_dim(dec_shift, MAX_H);
                POS_PLANES: begin
                    if (dec_shift[31:16] != 16'd1) begin
                        dec_phase = PH_REJECTED;
                        r.kind    = KIND_REJECT;
                        r.err     = ERR_PLANES;
                        got       = 1'b1;
                    end
                end
                POS_LAST: begin
                    got = 1'b1;
                    if (dec_shift != 32'd0) begin
                        dec_phase = PH_REJECTED;
                        r.kind    = KIND_REJECT;
                        r.err     = ERR_COMPRESS;
                    end else if (dec_width == 11'd0 || dec_width > 11'(MAX_W) ||
                                 dec_height == 11'd0 || dec_height > 11'(MAX_H) ||
                                 dec_offset < HEADER_LEN) begin
                        dec_phase = PH_REJECTED;
                        r.kind    = KIND_REJECT;
                        r.err     = ERR_SIZE;
                    end else begin
                        dec_phase = PH_SKIP;
                        dec_col   = '0;
                        dec_row   = '0;
                        dec_slot  = SLOT_FIRST;
                        r.kind    = KIND_ACCEPT;
                    end
                end
                default: ;
            endcase
        end else if (dec_phase == PH_SKIP && dec_pos < dec_offset) begin
            dec_pos = dec_pos + 32'd1;
        end else begin
            // first pixel byte leaves the skip phase without advancing the position
            if (dec_phase == PH_SKIP)
                dec_phase = PH_PIXELS;
            else if (dec_pos != 32'hFFFF_FFFF)
                dec_pos = dec_pos + 32'd1;
            case (dec_slot)
                SLOT_FIRST: begin
                    dec_b0   = b;
                    dec_slot = SLOT_SECOND;
                end
                SLOT_SECOND: begin
                    dec_b1   = b;
                    dec_slot = SLOT_THIRD;
                end
                default: begin
                    dec_slot = SLOT_FIRST;
                    y_full   = dec_height - 11'd1 - {1'b0, dec_row};
                    fin      = ({1'b0, dec_col} + 11'd1 == dec_width) &&
                               ({1'b0, dec_row} + 11'd1 == dec_height);
                    r.kind   = KIND_PIXEL;
                    r.x      = dec_col;
                    r.y      = y_full[PIX_W-1:0];
                    r.color  = {dec_b0[7:3], dec_b1[7:2], b[7:3]};
                    r.last   = fin;
                    got      = 1'b1;
                    if ({1'b0, dec_col} + 11'd1 >= dec_width) begin
                        dec_col = '0;
                        dec_row = dec_row + 1'b1;
                    end else begin
                        dec_col = dec_col + 1'b1;
                    end
                    if (fin)
                        dec_phase = PH_DONE;
                end
            endcase
        end
        if (got)
            due_results.push_back(r);
    endtask

    // Offer one byte after a random gap, hold it until taken, then decode it.
    task automatic send_byte(input logic [7:0] b, input logic start);
        int gap;
        gap = tx_idle ? $urandom_range(0, GAP_MAX) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tuser  <= start;
        do @(posedge i_clk); while (!o_s_tready);
        decode_byte(b, start);
    endtask

    task automatic send_bytes(input int n);
        repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // 34-byte header; size, creator, DIB size and bit depth are random filler
    task automatic send_file_header(input logic [15:0] magic, input logic [31:0] offs,
                                    input logic [31:0] w, input logic [31:0] h,
                                    input logic [15:0] planes, input logic [31:0] comp);
        logic [7:0] hdr [0:33];
        for (int k = 0; k < 34; k++)
            hdr[k] = 8'($urandom_range(0, 255));
        {hdr[1], hdr[0]}                    = magic;
        {hdr[13], hdr[12], hdr[11], hdr[10]} = offs;
        {hdr[21], hdr[20], hdr[19], hdr[18]} = w;
        {hdr[25], hdr[24], hdr[23], hdr[22]} = h;
        {hdr[27], hdr[26]}                   = planes;
        {hdr[33], hdr[32], hdr[31], hdr[30]} = comp;
        for (int k = 0; k < 34; k++)
            send_byte(hdr[k], k == 0);
    endtask

    // complete, well-formed file with random pixel content
    task automatic send_image(input int w, input int h, input int offs);
        send_file_header(BMP_MAGIC, 32'(offs), 32'(w), 32'(h), 16'd1, 32'd0);
        send_bytes(offs - int'(HEADER_LEN) + w * h * 3);
    endtask

    function automatic logic [31:0] oversize_dim(input int lim);
        case ($urandom_range(0, 3))
            0:       return 32'(lim + 1);
            1:       return 32'hFFFF_FFFF;
            2:       return {1'b1, 31'($urandom)};
            default: return 32'($urandom_range(lim + 1, 65535));
        endcase
    endfunction

    // --- directed tests ------------------------------------------------------

    task automatic test_bad_magic();
        send_byte(8'h42, 1'b1);
        send_byte(8'h00, 1'b0);
        send_bytes(2);              // ignored until the next file start
    endtask

    task automatic test_header_checks();
        send_file_header(BMP_MAGIC ^ 16'h8000, 32'd54, 32'd4, 32'd4, 16'd1, 32'd0);
        send_file_header(BMP_MAGIC, 32'd54, 32'd4, 32'd4, 16'd2, 32'd0);
        // planes checked before compression
        send_file_header(BMP_MAGIC, 32'd54, 32'd4, 32'd4, 16'hFFFF, 32'd1);
        send_file_header(BMP_MAGIC, 32'd54, 32'd4, 32'd4, 16'd1, 32'd1);
        // compression wins over a bad size
        send_file_header(BMP_MAGIC, 32'd0, 32'd0, 32'd0, 16'd1, 32'hFFFF_FFFF);
        send_file_header(BMP_MAGIC, 32'd54, 32'd0, 32'd4, 16'd1, 32'd0);
        send_file_header(BMP_MAGIC, 32'd54, 32'd4, 32'd1025, 16'd1, 32'd0);
        send_file_header(BMP_MAGIC, 32'd33, 32'd4, 32'd4, 16'd1, 32'd0);
        // largest legal size with the smallest legal offset
        send_file_header(BMP_MAGIC, HEADER_LEN, 32'd1024, 32'd1024, 16'd1, 32'd0);
    endtask

    task automatic test_tiny_images();
        // saturated and truncated channel bits, then bytes past the end
        send_file_header(BMP_MAGIC, HEADER_LEN, 32'd2, 32'd1, 16'd1, 32'd0);
        send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0);
        send_byte(8'h07, 1'b0); send_byte(8'h03, 1'b0); send_byte(8'h07, 1'b0);
        send_bytes(2);
        // one byte of gap before the pixel data
        send_file_header(BMP_MAGIC, 32'd35, 32'd1, 32'd1, 16'd1, 32'd0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
    endtask

    task automatic test_restart();
        // restart inside the header, then inside a pixel triple
        send_byte(8'h42, 1'b1);
        send_byte(8'h4D, 1'b0);
        send_bytes(8);
        send_file_header(BMP_MAGIC, 32'd40, 32'd2, 32'd2, 16'd1, 32'd0);
        send_bytes(6 + 4);
        send_image(3, 2, 34);
    endtask

    task automatic test_backpressure();
        // sink stops for a long stretch while the source runs flat out
        tx_idle  = 1'b0;
        hold_req = HOLD_CYCLES;
        send_image(8, 8, 34);
        tx_idle  = 1'b1;
    endtask

    task automatic test_wide_image();
        // largest image: the first file row lands on the top display row code
        send_file_header(BMP_MAGIC, HEADER_LEN, 32'd1024, 32'd1024, 16'd1, 32'd0);
        send_bytes(3 * 8);
    endtask

    // --- random files --------------------------------------------------------

    task automatic send_random_file();
        int          sel;
        int          n_data;
        logic [15:0] magic;
        logic [15:0] planes;
        logic [31:0] offs;
        logic [31:0] w;
        logic [31:0] h;
        logic [31:0] comp;
        magic  = BMP_MAGIC;
        planes = 16'd1;
        comp   = 32'd0;
        w      = $urandom_range(1, 8);
        h      = $urandom_range(1, 6);
        offs   = HEADER_LEN + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 24) : 0);
        sel    = $urandom_range(0, 99);
        if (sel < 5) begin
            magic = $urandom_range(0, 1) ? (magic ^ (16'd1 << $urandom_range(0, 15)))
                                         : 16'($urandom);
        end else if (sel < 10) begin
            planes = 16'($urandom);
            if (planes == 16'd1)
                planes = 16'd0;
        end else if (sel < 15) begin
            comp = 32'd1 << $urandom_range(0, 31);
        end else if (sel < 18) begin
            w = 32'd0;
        end else if (sel < 21) begin
            h = 32'd0;
        end else if (sel < 24) begin
            w = oversize_dim(MAX_W);
        end else if (sel < 27) begin
            h = oversize_dim(MAX_H);
        end else if (sel < 30) begin
            offs = $urandom_range(0, HEADER_LEN - 1);
        end else if (sel < 32) begin
            offs = {16'hFFFF, 16'($urandom)};
        end
        send_file_header(magic, offs, w, h, planes, comp);
        if (sel < 30) begin
            n_data = $urandom_range(0, 4);
        end else if (sel < 32) begin
            n_data = $urandom_range(10, 30);
        end else begin
            n_data = int'(offs - HEADER_LEN) + int'(w * h) * 3;
            if ($urandom_range(0, 9) == 0)
                n_data = $urandom_range(0, n_data - 1);
            else
                n_data += $urandom_range(0, 3);
        end
        send_bytes(n_data);
    endtask

    task automatic test_random_files();
        int base;
        base = n_parsed;
        while (n_parsed - base < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) tx_idle = ~tx_idle;
            if ($urandom_range(0, 9) == 0) rx_idle = ~rx_idle;
            if ($urandom_range(0, 11) == 0) begin
                // loose bytes with a stray file start now and then
                repeat ($urandom_range(1, 6))
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end else begin
                send_random_file();
            end
        end
    endtask

    // --- result side ---------------------------------------------------------

    // Result sink: stall a random number of cycles per request, or for the
    // long hold-off when one is asked for.
    initial begin
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = rx_idle ? $urandom_range(0, GAP_MAX) : 0;
            if (hold_req > 0) begin
                stall    = hold_req;
                hold_req = 0;
            end
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endtask

    // Compare every accepted result against the oldest one owed.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (due_results.size() == 0) begin
                $error("result_kind: expected none, got %0d", o_m_tuser);
                n_errors++;
            end else begin
                want = due_results.pop_front();
                compare_field("result_kind", want.kind,  o_m_tuser);
                compare_field("error_code",  want.err,   o_m_tdata[1:0]);
                compare_field("pixel_x",     want.x,     o_m_tdata[11:2]);
                compare_field("pixel_y",     want.y,     o_m_tdata[21:12]);
                compare_field("pixel_color", want.color, o_m_tdata[37:22]);
                compare_field("last_pixel",  want.last,  o_m_tlast);
                compare_field("tdata_pad",   0,          o_m_tdata[39:38]);
            end
        end
    end

    // --- sequence ------------------------------------------------------------

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_bad_magic();
        test_header_checks();
        test_tiny_images();
        test_restart();
        test_backpressure();
        test_wide_image();
        test_random_files();
        i_s_tvalid <= 1'b0;
        // drain what is still owed, then give the output stage time to misbehave
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
